@@ sv/pcbd_pkg.sv @@
package pcbd_pkg;

    // default sizes
    localparam int TABLE_ENTRIES = 256;
    localparam int MAX_CODE_LEN  = 16;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 8;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;

    // stream word widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_DECODE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // table entry broadcast to every cell on a load
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_entry;

    // match result handed from cell to cell
    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] symbol;
    } t_carry;

endpackage

@@ sv/pcbd_cell.sv @@
module pcbd_cell #(
    parameter int MAX_CODE_LEN = pcbd_pkg::MAX_CODE_LEN,
    parameter int CELL_IDX     = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  pcbd_pkg::t_entry                 i_entry,
    input  logic [MAX_CODE_LEN-1:0]          i_pend_code,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0] i_pend_cnt,
    input  pcbd_pkg::t_carry                 i_carry,
    output pcbd_pkg::t_carry                 o_carry
);

    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int CMP_W  = (MAX_CODE_LEN > pcbd_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : pcbd_pkg::CODE_W;
    localparam int LCMP_W = (CNT_W > pcbd_pkg::LEN_W) ? CNT_W : pcbd_pkg::LEN_W;

    logic [pcbd_pkg::SYM_W-1:0]  r_sym;
    logic [pcbd_pkg::CODE_W-1:0] r_code;
    logic [pcbd_pkg::LEN_W-1:0]  r_len;
    pcbd_pkg::t_carry            r_carry;
    pcbd_pkg::t_carry            n_carry;
    logic                        w_sel;
    logic                        w_match;

    assign w_sel = i_wr && (i_entry.idx == pcbd_pkg::IDX_W'(CELL_IDX));

    assign w_match = (r_len != '0)
                  && (LCMP_W'(r_len) == LCMP_W'(i_pend_cnt))
                  && (CMP_W'(r_code) == CMP_W'(i_pend_code));

    // a higher cell overrides whatever came up the chain
    always_comb begin
        n_carry = i_carry;
        if (w_match) begin
            n_carry.hit    = 1'b1;
            n_carry.symbol = r_sym;
        end
    end

    // zero length marks the entry empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (w_sel) begin
            r_len <= i_entry.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_sym  <= i_entry.symbol;
            r_code <= i_entry.code;
        end
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

endmodule

@@ sv/pcbd_chain.sv @@
module pcbd_chain #(
    parameter int TABLE_ENTRIES = pcbd_pkg::TABLE_ENTRIES,
    parameter int MAX_CODE_LEN  = pcbd_pkg::MAX_CODE_LEN
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  pcbd_pkg::t_entry                 i_entry,
    input  logic [MAX_CODE_LEN-1:0]          i_pend_code,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0] i_pend_cnt,
    output pcbd_pkg::t_carry                 o_tail
);

    pcbd_pkg::t_carry w_carry [TABLE_ENTRIES+1];

    assign w_carry[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        pcbd_cell #(
            .MAX_CODE_LEN (MAX_CODE_LEN),
            .CELL_IDX     (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr        (i_wr),
            .i_entry     (i_entry),
            .i_pend_code (i_pend_code),
            .i_pend_cnt  (i_pend_cnt),
            .i_carry     (w_carry[g]),
            .o_carry     (w_carry[g+1])
        );
    end

    assign o_tail = w_carry[TABLE_ENTRIES];

endmodule

@@ sv/prefix_code_bit_decoder.sv @@
// channel   dir  tdata (low bit up)                                 tuser
// s_axis    in   entry_index, entry_symbol, entry_code,             command
//                entry_length, bit_value, 2 zero bits
// m_axis    out  symbol                                             overflow
//
// load and clear transactions complete on acceptance, leaving the decoder ready for the next transaction
// a decode walks the match result along the row of cells, one cell per cycle from the lowest
// entry to the highest, and on a match hands the result off to the output register
// a decode that overflows skips the walk and goes straight to the hand-off to the output register
// reset is synchronous and empties every entry and the pending code
// a stalled result in the output register holds the next decoded result at its hand-off
module prefix_code_bit_decoder #(
    parameter int TABLE_ENTRIES = pcbd_pkg::TABLE_ENTRIES,
    parameter int MAX_CODE_LEN  = pcbd_pkg::MAX_CODE_LEN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // entry_index, entry_symbol, entry_code, entry_length, bit_value, pad
    input  logic [pcbd_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // command
    input  logic [pcbd_pkg::CMD_W-1:0]      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // symbol
    output logic [pcbd_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // overflow
    output logic [0:0]                      o_m_axis_tuser
);

    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int WALK_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LENX_W = pcbd_pkg::LEN_W + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [MAX_CODE_LEN-1:0]     r_pend_code, n_pend_code;
    logic [CNT_W-1:0]            r_pend_cnt, n_pend_cnt;
    logic [WALK_W-1:0]           r_walk_cnt, n_walk_cnt;
    logic [pcbd_pkg::SYM_W-1:0]  r_res_sym, n_res_sym;
    logic                        r_res_ovf, n_res_ovf;
    logic                        r_out_valid, n_out_valid;
    logic [pcbd_pkg::SYM_W-1:0]  r_out_sym, n_out_sym;
    logic                        r_out_ovf, n_out_ovf;

    logic                        w_s_fire;
    pcbd_pkg::t_cmd              w_cmd;
    logic                        w_bit;
    logic [pcbd_pkg::LEN_W-1:0]  w_in_len;
    logic [pcbd_pkg::LEN_W-1:0]  w_len;
    logic [pcbd_pkg::CODE_W-1:0] w_mask;
    pcbd_pkg::t_entry            w_entry;
    logic                        w_wr;
    pcbd_pkg::t_carry            w_tail;
    logic                        w_out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd           = pcbd_pkg::t_cmd'(i_s_axis_tuser);
    assign w_bit           = i_s_axis_tdata[37];
    assign w_in_len        = i_s_axis_tdata[36:32];

    // overlong entries are stored empty, code bits above the length dropped
    assign w_len = ({1'b0, w_in_len} > LENX_W'(MAX_CODE_LEN)) ? '0 : w_in_len;

    always_comb begin
        for (int b = 0; b < pcbd_pkg::CODE_W; b++) begin
            w_mask[b] = (pcbd_pkg::LEN_W'(b) < w_len);
        end
    end

    assign w_entry.idx    = i_s_axis_tdata[7:0];
    assign w_entry.symbol = i_s_axis_tdata[15:8];
    assign w_entry.code   = i_s_axis_tdata[31:16] & w_mask;
    assign w_entry.len    = w_len;
    assign w_wr           = w_s_fire && (w_cmd == pcbd_pkg::CMD_LOAD);

    pcbd_chain #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_entry     (w_entry),
        .i_pend_code (r_pend_code),
        .i_pend_cnt  (r_pend_cnt),
        .o_tail      (w_tail)
    );

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_pend_code = r_pend_code;
        n_pend_cnt  = r_pend_cnt;
        n_walk_cnt  = r_walk_cnt;
        n_res_sym   = r_res_sym;
        n_res_ovf   = r_res_ovf;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_sym   = r_out_sym;
        n_out_ovf   = r_out_ovf;

        case (r_state)
            S_IDLE: begin
                if (w_s_fire) begin
                    case (w_cmd)
                        pcbd_pkg::CMD_CLEAR: begin
                            n_pend_code = '0;
                            n_pend_cnt  = '0;
                        end
                        pcbd_pkg::CMD_DECODE: begin
                            if (r_pend_cnt >= CNT_W'(MAX_CODE_LEN)) begin
                                // the overflowing bit goes with the pending code
                                n_pend_code = '0;
                                n_pend_cnt  = '0;
                                n_res_sym   = '0;
                                n_res_ovf   = 1'b1;
                                n_state     = S_EMIT;
                            end else begin
                                n_pend_code = {r_pend_code[MAX_CODE_LEN-2:0], w_bit};
                                n_pend_cnt  = r_pend_cnt + 1'b1;
                                n_walk_cnt  = '0;
                                n_state     = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                // tail holds the verdict once every cell has seen the new code
                if (r_walk_cnt == WALK_W'(TABLE_ENTRIES)) begin
                    if (w_tail.hit) begin
                        n_pend_code = '0;
                        n_pend_cnt  = '0;
                        n_res_sym   = w_tail.symbol;
                        n_res_ovf   = 1'b0;
                        n_state     = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_walk_cnt = r_walk_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = r_res_sym;
                    n_out_ovf   = r_res_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_code <= '0;
            r_pend_cnt  <= '0;
            r_walk_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_code <= n_pend_code;
            r_pend_cnt  <= n_pend_cnt;
            r_walk_cnt  <= n_walk_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_sym <= n_res_sym;
        r_res_ovf <= n_res_ovf;
        r_out_sym <= n_out_sym;
        r_out_ovf <= n_out_ovf;
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_sym;
    assign o_m_axis_tuser[0] = r_out_ovf;

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_EMIT))
        else $error("result shown without a finished decode");

    a_ovf_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("overflow result carries a symbol");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= CNT_W'(MAX_CODE_LEN))
        else $error("pending bit count past maximum code length");

    a_decode_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && (w_cmd == pcbd_pkg::CMD_DECODE)
            && (r_pend_cnt < CNT_W'(MAX_CODE_LEN))) |=> (r_state == S_WALK))
        else $error("decode bit did not start a table walk");

endmodule
